// ===== rtl/prru_pkg.sv =====
// ----------------------------------------------------------------------------
// prru_pkg
// Shared types, codes and the reciprocal table for the permutation
// rank/unrank block.
// ----------------------------------------------------------------------------
package prru_pkg;

   localparam int MaxLengthDefault = 12;

   localparam int ElemW = 4;
   localparam int RankW = 29;
   localparam int LenW  = 4;
   localparam int RecipW = 32;

   localparam logic [LenW-1:0] LenReset = 4'd9;

   // opcodes
   localparam logic OpPush   = 1'b0;
   localparam logic OpUnrank = 1'b1;

   // result kinds
   localparam logic KindRank = 1'b0;
   localparam logic KindElem = 1'b1;

   // one queued word between front and back
   typedef struct packed {
      logic             unrank;
      logic [ElemW-1:0] element;
      logic [RankW-1:0] rank;
   } queue_item_type;

   // back-end status seen by the top level
   typedef struct packed {
      logic idle;      // nothing executing, output register empty
      logic seq_open;  // a rank sequence has elements pending
   } back_status_type;

   // floor(2^32 / d) for the radices in use
   function automatic logic [RecipW-1:0] recip(input logic [4:0] d);
      logic [RecipW-1:0] m;
      begin
         case (d)
            5'd2:    m = 32'd2147483648;
            5'd3:    m = 32'd1431655765;
            5'd4:    m = 32'd1073741824;
            5'd5:    m = 32'd858993459;
            5'd6:    m = 32'd715827882;
            5'd7:    m = 32'd613566756;
            5'd8:    m = 32'd536870912;
            5'd9:    m = 32'd477218588;
            5'd10:   m = 32'd429496729;
            5'd11:   m = 32'd390451572;
            5'd12:   m = 32'd357913941;
            5'd13:   m = 32'd330382099;
            5'd14:   m = 32'd306783378;
            5'd15:   m = 32'd286331153;
            5'd16:   m = 32'd268435456;
            5'd17:   m = 32'd252645135;
            5'd18:   m = 32'd238609294;
            5'd19:   m = 32'd226050910;
            5'd20:   m = 32'd214748364;
            default: m = '0;
         endcase
         return m;
      end
   endfunction

endpackage

// ===== rtl/prru_front.sv =====
// ----------------------------------------------------------------------------
// prru_front
// Input side: takes request words, tags push vs. unrank, and holds them in
// a two-word queue for the execution back end.
// ----------------------------------------------------------------------------
module prru_front
   import prru_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_opcode,
   input  logic [ElemW-1:0]     req_element,
   input  logic [RankW-1:0]     req_rank_in,
   output logic                 q_valid,
   output queue_item_type       q_item,
   input  logic                 q_take
);

   queue_item_type slot_ff [2];
   queue_item_type slot_in;
   logic [1:0]     count_ff, count_in;
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic           push_w;

   assign req_stall = (count_ff == 2'd2);
   assign push_w    = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      slot_in.unrank  = (req_opcode == OpUnrank);
      slot_in.element = req_element;
      slot_in.rank    = req_rank_in;
      wr_ptr_in = push_w ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_take ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push_w) - 2'(q_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_w) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
   end

endmodule

// ===== rtl/prru_back.sv =====
// ----------------------------------------------------------------------------
// prru_back
// Execution side: folds pushed elements into the mixed-radix rank, and
// unranks through a reciprocal-multiply divider with an element fixup pass.
// ----------------------------------------------------------------------------
module prru_back
   import prru_pkg::*;
#(
   parameter int MAX_LENGTH = MaxLengthDefault
)
(
   input  logic                               clock,
   input  logic                               reset,
   input  logic [$clog2(MAX_LENGTH+1)-1:0]    n_use,
   input  logic                               cfg_clear,
   input  logic                               q_valid,
   input  queue_item_type                     q_item,
   output logic                               q_take,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_kind,
   output logic [ElemW-1:0]                   rsp_element_out,
   output logic [RankW-1:0]                   rsp_rank_out,
   output logic                               rsp_not_permutation,
   output logic                               rsp_last,
   output back_status_type                    status
);

   localparam int NW = $clog2(MAX_LENGTH + 1);
   localparam int IW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
   localparam int EW = IW;
   localparam int PW = RankW + RecipW;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_FIX  = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [NW-1:0]         pos_ff, pos_in;
   logic [RankW-1:0]      acc_ff, acc_in;
   logic [MAX_LENGTH-1:0] used_ff, used_in;
   logic [RankW-1:0]      r_ff, r_in;
   logic [PW-1:0]         prod_ff, prod_in;
   logic [IW-1:0]         idx_ff, idx_in;
   logic [IW-1:0]         fix_idx_ff, fix_idx_in;
   logic [NW-1:0]         radix_ff, radix_in;
   logic [EW-1:0]         dig_ff, dig_in;
   logic                  fix_ff, fix_in;
   logic [EW-1:0]         elt_ff [MAX_LENGTH];
   logic [EW-1:0]         elt_in [MAX_LENGTH];

   logic                  out_valid_ff, out_valid_in;
   logic                  out_kind_ff, out_kind_in;
   logic [ElemW-1:0]      out_elem_ff, out_elem_in;
   logic [RankW-1:0]      out_rank_ff, out_rank_in;
   logic                  out_bad_ff, out_bad_in;
   logic                  out_last_ff, out_last_in;

   logic                  out_free;

   // push datapath
   logic                  is_used;
   logic                  in_range;
   logic                  elem_ok;
   logic [MAX_LENGTH-1:0] below;
   logic [MAX_LENGTH-1:0] onehot;
   logic [MAX_LENGTH-1:0] used_new;
   logic [NW-1:0]         smaller;
   logic [NW-1:0]         ones;
   logic [NW-1:0]         pos_next;
   logic [NW-1:0]         radix_r;
   logic [RankW+NW-1:0]   acc_prod;
   logic [RankW-1:0]      digit;
   logic                  seq_done;
   logic                  bad;

   // divider datapath
   logic [RankW-1:0]      q_est;
   logic [RankW+NW-1:0]   qr;
   logic [RankW-1:0]      rem_w;
   logic                  corr;
   logic [RankW-1:0]      rem;
   logic [RankW-1:0]      quot;

   assign out_free = !out_valid_ff || !rsp_stall;

   assign rsp_valid           = out_valid_ff;
   assign rsp_kind            = out_kind_ff;
   assign rsp_element_out     = out_elem_ff;
   assign rsp_rank_out        = out_rank_ff;
   assign rsp_not_permutation = out_bad_ff;
   assign rsp_last            = out_last_ff;

   assign status.idle     = (state_ff == ST_IDLE) && !out_valid_ff;
   assign status.seq_open = (pos_ff != '0);

   // smaller earlier elements = used bits below e; once a bad element is
   // seen the rank is dropped anyway, so this matches the earlier-element scan
   always_comb begin
      is_used = 1'b0;
      smaller = '0;
      for (int k = 0; k < MAX_LENGTH; k++) begin
         onehot[k] = (32'(k) == 32'(q_item.element));
         below[k]  = (32'(k) < 32'(q_item.element));
         is_used   = is_used | (onehot[k] & used_ff[k]);
         smaller   = smaller + NW'(used_ff[k] & below[k]);
      end
      in_range = (32'(q_item.element) < 32'(n_use));
      elem_ok  = in_range && !is_used;
      used_new = used_ff | (elem_ok ? onehot : '0);
      ones = '0;
      for (int k = 0; k < MAX_LENGTH; k++) begin
         ones = ones + NW'(used_new[k]);
      end
      pos_next = pos_ff + NW'(1);
      radix_r  = n_use - pos_ff;
      acc_prod = acc_ff * radix_r;
      digit    = RankW'(q_item.element) - RankW'(smaller);
      seq_done = (pos_next == n_use);
      bad      = (ones != n_use);
   end

   // quotient estimate is exact or one low; one correction step
   always_comb begin
      q_est = prod_ff[PW-1:RecipW];
      qr    = q_est * radix_ff;
      rem_w = r_ff - qr[RankW-1:0];
      corr  = (rem_w >= RankW'(radix_ff));
      rem   = corr ? (rem_w - RankW'(radix_ff)) : rem_w;
      quot  = q_est + RankW'(corr);
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      acc_in       = acc_ff;
      used_in      = used_ff;
      r_in         = r_ff;
      prod_in      = prod_ff;
      idx_in       = idx_ff;
      fix_idx_in   = fix_idx_ff;
      radix_in     = radix_ff;
      dig_in       = dig_ff;
      fix_in       = fix_ff;
      elt_in       = elt_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_kind_in  = out_kind_ff;
      out_elem_in  = out_elem_ff;
      out_rank_in  = out_rank_ff;
      out_bad_in   = out_bad_ff;
      out_last_in  = out_last_ff;
      q_take       = 1'b0;

      // bump later elements at or above the digit just placed
      if ((state_ff == ST_MUL && fix_ff) || state_ff == ST_FIX) begin
         for (int j = 0; j < MAX_LENGTH; j++) begin
            if (32'(j) > 32'(fix_idx_ff) && elt_ff[j] >= dig_ff) begin
               elt_in[j] = elt_ff[j] + EW'(1);
            end
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_valid && (q_item.unrank || out_free)) begin
               q_take = 1'b1;
               if (q_item.unrank) begin
                  r_in     = q_item.rank;
                  idx_in   = IW'(n_use - NW'(2));
                  radix_in = NW'(2);
                  fix_in   = 1'b0;
                  for (int j = 0; j < MAX_LENGTH; j++) begin
                     elt_in[j] = '0;
                  end
                  state_in = ST_MUL;
               end else begin
                  pos_in  = pos_next;
                  used_in = used_new;
                  if (elem_ok && (pos_next < n_use)) begin
                     acc_in = acc_prod[RankW-1:0] + digit;
                  end
                  if (seq_done) begin
                     out_valid_in = 1'b1;
                     out_kind_in  = KindRank;
                     out_elem_in  = '0;
                     out_rank_in  = bad ? '0 : acc_ff;
                     out_bad_in   = bad;
                     out_last_in  = 1'b1;
                     pos_in       = '0;
                     acc_in       = '0;
                     used_in      = '0;
                  end
               end
            end
         end
         ST_MUL: begin
            prod_in  = r_ff * recip(5'(radix_ff));
            fix_in   = 1'b0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            elt_in[idx_ff] = EW'(rem);
            dig_in         = EW'(rem);
            fix_idx_in     = idx_ff;
            fix_in         = 1'b1;
            r_in           = quot;
            if (idx_ff == '0) begin
               state_in = ST_FIX;
            end else begin
               idx_in   = idx_ff - IW'(1);
               radix_in = radix_ff + NW'(1);
               state_in = ST_MUL;
            end
         end
         ST_FIX: begin
            fix_in   = 1'b0;
            idx_in   = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = KindElem;
               out_elem_in  = ElemW'(elt_ff[idx_ff]);
               out_rank_in  = '0;
               out_bad_in   = 1'b0;
               out_last_in  = (idx_ff == IW'(n_use - NW'(1)));
               if (idx_ff == IW'(n_use - NW'(1))) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + IW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cfg_clear) begin
         pos_in  = '0;
         acc_in  = '0;
         used_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         acc_ff       <= '0;
         used_ff      <= '0;
         fix_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         acc_ff       <= acc_in;
         used_ff      <= used_in;
         fix_ff       <= fix_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff        <= r_in;
      prod_ff     <= prod_in;
      idx_ff      <= idx_in;
      fix_idx_ff  <= fix_idx_in;
      radix_ff    <= radix_in;
      dig_ff      <= dig_in;
      elt_ff      <= elt_in;
      out_kind_ff <= out_kind_in;
      out_elem_ff <= out_elem_in;
      out_rank_ff <= out_rank_in;
      out_bad_ff  <= out_bad_in;
      out_last_ff <= out_last_in;
   end

endmodule

// ===== rtl/permutation_rank_unrank.sv =====
// ----------------------------------------------------------------------------
// permutation_rank_unrank
// Lehmer-code permutation ranking and unranking for lengths 2..MAX_LENGTH.
// ----------------------------------------------------------------------------
// Push words (opcode 0) carry one element each; after n of them one rank
// word comes out, flagged not_permutation with rank 0 if an element repeated
// or was not below n. An unrank word (opcode 1) reads rank_in modulo n! and
// returns n element words in position order: per digit the single divider
// does a reciprocal multiply (MUL) then a correction (DIV), the fixup of
// later elements rides on the next MUL or a final FIX, and EMIT then sends
// the words. No new word leaves the queue until an unrank is through. A
// two-word queue sits between the input and the back end, so requests are
// taken while a result waits on a stalled output. perm_length is clamped
// into 2..MAX_LENGTH, and writing it drops any partial rank sequence; it is
// accepted only while the block is drained.
module permutation_rank_unrank
   import prru_pkg::*;
#(
   parameter int MAX_LENGTH = MaxLengthDefault
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_opcode,
   input  logic [ElemW-1:0]  req_element,
   input  logic [RankW-1:0]  req_rank_in,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_kind,
   output logic [ElemW-1:0]  rsp_element_out,
   output logic [RankW-1:0]  rsp_rank_out,
   output logic              rsp_not_permutation,
   output logic              rsp_last,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [LenW-1:0]   csr_data
);

   localparam int NW = $clog2(MAX_LENGTH + 1);

   logic [LenW-1:0]  perm_len_ff, perm_len_in;
   logic [NW-1:0]    n_use;
   logic             cfg_write;
   logic             q_valid;
   logic             q_take;
   queue_item_type   q_item;
   back_status_type  status;

   // register write only while drained
   assign csr_ready = status.idle && !q_valid;
   assign cfg_write = csr_valid && csr_ready;
   assign perm_len_in = cfg_write ? csr_data : perm_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         perm_len_ff <= LenReset;
      end else begin
         perm_len_ff <= perm_len_in;
      end
   end

   // clamp length into 2..MAX_LENGTH
   always_comb begin
      if (perm_len_ff < LenW'(2)) begin
         n_use = NW'(2);
      end else if (32'(perm_len_ff) > 32'(MAX_LENGTH)) begin
         n_use = NW'(MAX_LENGTH);
      end else begin
         n_use = NW'(perm_len_ff);
      end
   end

   prru_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_opcode  (req_opcode),
      .req_element (req_element),
      .req_rank_in (req_rank_in),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_take      (q_take)
   );

   prru_back #(
      .MAX_LENGTH (MAX_LENGTH)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .n_use               (n_use),
      .cfg_clear           (cfg_write),
      .q_valid             (q_valid),
      .q_item              (q_item),
      .q_take              (q_take),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_element_out     (rsp_element_out),
      .rsp_rank_out        (rsp_rank_out),
      .rsp_not_permutation (rsp_not_permutation),
      .rsp_last            (rsp_last),
      .status              (status)
   );

   // a flagged rank word carries rank 0, and is always the last word
   a_bad_rank_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KindRank && rsp_not_permutation
         |-> rsp_rank_out == '0 && rsp_last)
      else $error("flagged rank word with nonzero rank or not last");

   // element words carry no rank and no flag, and stay below n
   a_elem_word_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KindElem
         |-> rsp_rank_out == '0 && !rsp_not_permutation
             && 32'(rsp_element_out) < 32'(n_use))
      else $error("bad element word");

   // a length write drops the open rank sequence
   a_cfg_clears_seq: assert property (@(posedge clock) disable iff (reset)
      cfg_write |=> !status.seq_open)
      else $error("rank sequence survived length write");

   // queue words are only taken while something is queued
   a_take_needs_valid: assert property (@(posedge clock) disable iff (reset)
      q_take |-> q_valid)
      else $error("queue taken while empty");

endmodule

// ===== tb/tb_permutation_rank_unrank.sv =====
// ----------------------------------------------------------------------------
// tb_permutation_rank_unrank
// Self-checking bench for the Lehmer-code rank/unrank block. A predictor
// written in plain SystemVerilog folds pushed elements into ranks and expands
// unrank words into element lists. Its results are queued and compared
// against every word the block returns. Stimulus covers directed corner
// cases, random phases across several length settings, random idling on both
// channels, and one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_permutation_rank_unrank;
   timeunit 1ns;
   timeprecision 1ps;

   import prru_pkg::*;

   localparam int MAX_LEN      = 12;
   localparam int SETTLE       = 3 * MAX_LEN + 16;   // worst unrank plus slack
   localparam int LIMIT_CYCLES = 1_500_000;
   localparam int PHASE_WORDS  = 52;

   // length settings of the random phases; extremes and out-of-range included
   localparam logic [LenW-1:0] PHASE_LENGTHS [8] =
      '{4'd1, 4'd4, 4'd13, 4'd7, 4'd2, 4'd12, 4'd5, 4'd10};

   typedef struct packed {
      logic             kind;
      logic [ElemW-1:0] element;
      logic [RankW-1:0] rank;
      logic             not_perm;
      logic             last;
   } result_word_type;

   typedef logic [ElemW-1:0] elem_list_type [MAX_LEN];

   logic             clock;
   logic             reset               = 1'b1;
   logic             req_valid           = 1'b0;
   logic             req_stall;
   logic             req_opcode          = OpPush;
   logic [ElemW-1:0] req_element         = '0;
   logic [RankW-1:0] req_rank_in         = '0;
   logic             rsp_valid;
   logic             rsp_stall           = 1'b0;
   logic             rsp_kind;
   logic [ElemW-1:0] rsp_element_out;
   logic [RankW-1:0] rsp_rank_out;
   logic             rsp_not_permutation;
   logic             rsp_last;
   logic             csr_valid           = 1'b0;
   logic             csr_ready;
   logic [LenW-1:0]  csr_data            = '0;

   // predictor state: length register and the open rank sequence
   logic [LenW-1:0]  length_reg = LenReset;
   logic [ElemW-1:0] seen_elements [MAX_LEN];
   int unsigned      seq_pos    = 0;
   longint unsigned  seq_rank   = 0;
   logic [15:0]      seq_used   = '0;

   result_word_type  due_words[$];     // expected words, oldest first
   int               fail_count   = 0;
   int               cycle_count  = 0;
   int               hold_off_len = 0;  // set by a test, consumed by the receiver
   bit               idling_on    = 1'b1;

   permutation_rank_unrank #(.MAX_LENGTH(MAX_LEN)) u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_element         (req_element),
      .req_rank_in         (req_rank_in),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_element_out     (rsp_element_out),
      .rsp_rank_out        (rsp_rank_out),
      .rsp_not_permutation (rsp_not_permutation),
      .rsp_last            (rsp_last),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_data            (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // register value clamped into 2..MAX_LEN
   function automatic int unsigned active_length();
      if (length_reg < 2) return 2;
      if (length_reg > MAX_LEN) return MAX_LEN;
      return length_reg;
   endfunction

   function automatic void clear_sequence();
      seq_pos  = 0;
      seq_rank = 0;
      seq_used = '0;
   endfunction

   // One pushed element: reduce by smaller earlier elements, fold in mixed
   // radix; after the n-th element queue the rank word.
   function automatic void fold_element(input logic [ElemW-1:0] e);
      int unsigned     n;
      int unsigned     smaller;
      bit              ok;
      result_word_type w;
      n  = active_length();
      ok = (e < n) && !seq_used[e];
      if (ok) begin
         smaller = 0;
         for (int j = 0; j < seq_pos; j++)
            if (seen_elements[j] < e) smaller++;
         // last position has radix 1, nothing to fold
         if (seq_pos + 1 < n) seq_rank = seq_rank * (n - seq_pos) + (e - smaller);
         seq_used[e] = 1'b1;
      end
      // bad elements still take a position and count for later comparisons
      seen_elements[seq_pos] = e;
      seq_pos++;
      if (seq_pos == n) begin
         w          = '0;
         w.kind     = KindRank;
         w.not_perm = ($countones(seq_used) != n);
         w.rank     = w.not_perm ? '0 : seq_rank[RankW-1:0];
         w.last     = 1'b1;
         due_words.push_back(w);
         clear_sequence();
      end
   endfunction

   // Unrank: peel factorial digits from the right, lift later digits past
   // each placed one; rank is taken modulo n! by the divisions themselves.
   function automatic void expand_rank(input logic [RankW-1:0] r_in);
      int unsigned     n;
      int unsigned     radix;
      longint unsigned r;
      int unsigned     digits [MAX_LEN];
      result_word_type w;
      n     = active_length();
      r     = r_in;
      radix = 2;
      digits[n-1] = 0;
      for (int i = n - 2; i >= 0; i--) begin
         digits[i] = 32'(r % radix);
         r         = r / radix;
         for (int j = i + 1; j < n; j++)
            if (digits[j] >= digits[i]) digits[j]++;
         radix++;
      end
      for (int i = 0; i < n; i++) begin
         w         = '0;
         w.kind    = KindElem;
         w.element = ElemW'(digits[i]);
         w.last    = (i == n - 1);
         due_words.push_back(w);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // mostly short gaps, now and then a long one
   function automatic int idle_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
   endfunction

   // rank for an n-element unrank: in range, top of range, or any 29-bit value
   function automatic logic [RankW-1:0] random_rank(input int unsigned n);
      longint unsigned f;
      f = 1;
      for (int i = 2; i <= n; i++) f = f * i;
      case ($urandom_range(0, 3))
         0: return RankW'($urandom);
         1: return RankW'(f - 1);
         default: return RankW'($urandom_range(0, int'(f - 1)));
      endcase
   endfunction

   function automatic void shuffle_elements(input int unsigned n, output elem_list_type perm);
      int unsigned      j;
      logic [ElemW-1:0] t;
      for (int i = 0; i < MAX_LEN; i++) perm[i] = ElemW'(i);
      for (int i = n - 1; i > 0; i--) begin
         j       = $urandom_range(0, i);
         t       = perm[i];
         perm[i] = perm[j];
         perm[j] = t;
      end
   endfunction

   // Offer one word, hold it until accepted, then predict. Valid is only
   // dropped when a gap is taken, so back-to-back words keep it high.
   task automatic send_word(input logic op, input logic [ElemW-1:0] e,
                            input logic [RankW-1:0] r);
      int gap;
      gap = (idling_on && $urandom_range(0, 2) == 0) ? idle_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_opcode  <= op;
      req_element <= e;
      req_rank_in <= r;
      do @(posedge clock); while (req_stall);
      if (op == OpPush) fold_element(e);
      else expand_rank(r);
   endtask

   // unused payload fields carry random content
   task automatic send_push(input logic [ElemW-1:0] e);
      send_word(OpPush, e, RankW'($urandom));
   endtask

   task automatic send_unrank(input logic [RankW-1:0] r);
      send_word(OpUnrank, ElemW'($urandom), r);
   endtask

   // Stop offering, wait for every expected word, then let a trailing
   // unrank or push finish inside the block.
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (due_words.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // length write; block is drained first, the write drops any open sequence
   task automatic write_length(input logic [LenW-1:0] value);
      wait_drain();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      length_reg = value;
      clear_sequence();
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // reset length of 9: top and bottom of the rank range
   task automatic test_reset_length();
      idling_on = 1'b1;
      send_unrank(29'd362879);
      send_unrank(29'd0);
   endtask

   // register 0 clamps to length 2: good, repeated and out-of-range elements,
   // rank above n! wraps
   task automatic test_short_length();
      write_length(4'd0);
      send_push(4'd1);
      send_push(4'd0);
      send_push(4'd1);
      send_push(4'd1);
      send_push(4'd5);
      send_push(4'd0);
      send_unrank(29'd3);
   endtask

   // register 15 clamps to 12: largest ranks, then an open sequence that the
   // next length write abandons
   task automatic test_long_length();
      write_length(4'd15);
      send_unrank('1);
      send_unrank(29'd479001599);
      send_push(4'd11);
      send_push(4'd3);
      send_push(4'd7);
   endtask

   // unrank slipped into the middle of a rank sequence leaves it untouched
   task automatic test_interleave();
      write_length(4'd3);
      send_push(4'd2);
      send_unrank(29'd5);
      send_push(4'd0);
      send_push(4'd1);
   endtask

   // high element bits: elements far past the length
   task automatic test_element_bits();
      send_push(4'd15);
      send_push(4'd0);
      send_push(4'd1);
      send_push(4'd8);
      send_push(4'd4);
      send_push(4'd2);
   endtask

   // Random phases over several lengths. Mostly whole permutations with an
   // occasional unrank inside, plus lone unranks, permutations with one
   // element broken, and runs of random elements.
   task automatic test_random_traffic();
      elem_list_type perm;
      int unsigned   n;
      int unsigned   pick;
      int unsigned   sent;
      for (int k = 0; k < 8; k++) begin
         write_length((k == 7) ? LenW'($urandom_range(0, 15)) : PHASE_LENGTHS[k]);
         idling_on = (k % 3 != 2);   // every third phase runs flat out
         n         = active_length();
         sent      = 0;
         while (sent < PHASE_WORDS) begin
            pick = $urandom_range(0, 19);
            if (pick < 13) begin
               shuffle_elements(n, perm);
               for (int i = 0; i < n; i++) begin
                  send_push(perm[i]);
                  if ($urandom_range(0, 15) == 0) begin
                     send_unrank(random_rank(n));
                     sent++;
                  end
               end
               sent += n;
            end else if (pick < 16) begin
               send_unrank(random_rank(n));
               sent++;
            end else if (pick < 18) begin
               shuffle_elements(n, perm);
               perm[$urandom_range(0, n - 1)] = ElemW'($urandom_range(0, 15));
               for (int i = 0; i < n; i++) send_push(perm[i]);
               sent += n;
            end else begin
               for (int i = 0; i < n; i++) send_push(ElemW'($urandom_range(0, 15)));
               sent += n;
            end
         end
      end
   endtask

   // Receiver holds off for a long stretch while the sender keeps offering;
   // output register and queue fill and the input stalls.
   task automatic test_output_hold_off();
      elem_list_type perm;
      write_length(4'd12);
      idling_on    = 1'b0;
      hold_off_len = 300;
      for (int i = 0; i < 6; i++) send_unrank(random_rank(12));
      shuffle_elements(12, perm);
      for (int i = 0; i < 12; i++) send_push(perm[i]);
      idling_on = 1'b1;
   endtask

   // ------------------------------------------------------------------------
   // Receiver: random stalls, or one long hold-off when a test asks for it
   // ------------------------------------------------------------------------
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_len != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_off_len) @(posedge clock);
            hold_off_len = 0;
            rsp_stall <= 1'b0;
         end else if (idling_on && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat (idle_length()) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Checker: each accepted word against the oldest expectation
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_words
      result_word_type got;
      result_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind     = rsp_kind;
         got.element  = rsp_element_out;
         got.rank     = rsp_rank_out;
         got.not_perm = rsp_not_permutation;
         got.last     = rsp_last;
         if (due_words.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected word: kind=%0d elem=%0d rank=%0d bad=%0d last=%0d",
                        got.kind, got.element, got.rank, got.not_perm, got.last);
         end else begin
            want = due_words.pop_front();
            if (got !== want) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $write("mismatch: expected kind=%0d elem=%0d rank=%0d bad=%0d last=%0d,",
                         want.kind, want.element, want.rank, want.not_perm, want.last);
                  $display(" got kind=%0d elem=%0d rank=%0d bad=%0d last=%0d",
                           got.kind, got.element, got.rank, got.not_perm, got.last);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_reset_length();
      test_short_length();
      test_long_length();
      test_interleave();
      test_element_bits();
      test_random_traffic();
      test_output_hold_off();
      wait_drain();
      if (fail_count == 0 && due_words.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
